FILE: design/aqe_pkg.sv
// ---------------------------------------------------------------------------
// aqe_pkg: shared types and constants of the quadrature emulator
// Field structs for the request and result channels, the per-axis state
// record, configuration view and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package aqe_pkg;

    localparam int ANGLE_W    = 16;                 // angle is a fraction of a turn
    localparam int COUNT_W    = 16;                 // position count and period width
    localparam int CPR_W      = 14;                 // cycles per revolution register
    localparam int CFG_IDX_W  = 2;
    localparam int AXES_W     = 2;
    localparam int MAX_COUNTS = 9000;
    localparam int PROD_W     = ANGLE_W + COUNT_W;

    localparam logic [ANGLE_W-1:0]  ANGLE_HALF = {1'b1, {(ANGLE_W-1){1'b0}}};
    localparam logic [CPR_W-1:0]    CPR_MAX    = CPR_W'(MAX_COUNTS);
    localparam logic [CPR_W-1:0]    CPR_MIN    = CPR_W'(1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CPR_ONE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CPR_TWO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXES    = 2'd2;

    // request kinds
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_INIT   = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [ANGLE_W-1:0] angle_one;
        logic [ANGLE_W-1:0] angle_two;
    } t_in;

    typedef struct packed {
        logic               chan_a_one;
        logic               chan_b_one;
        logic               chan_a_two;
        logic               chan_b_two;
        logic               index_pulse;
        logic [COUNT_W-1:0] count_one;
        logic [COUNT_W-1:0] count_two;
        logic               rejected;
    } t_out;

    typedef struct packed {
        logic               calibrated;
        logic               phase_a;
        logic               phase_b;
        logic               index;
        logic [COUNT_W-1:0] position;
        logic [ANGLE_W-1:0] last_angle;
    } t_axis_st;

    typedef struct packed {
        logic [COUNT_W-1:0] period_one;
        logic [COUNT_W-1:0] period_two;
        logic               two_axes;
        logic               clr_one;
        logic               clr_two;
    } t_cfg;

endpackage

`default_nettype wire

FILE: design/aqe_cfg.sv
// ---------------------------------------------------------------------------
// aqe_cfg: configuration registers
// Holds cycles per revolution for both axes and the active axis count,
// clamps the counts and presents the x4 periods and position clear strobes.
// ---------------------------------------------------------------------------
`default_nettype none

module aqe_cfg (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [aqe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [aqe_pkg::CPR_W-1:0]     i_cfg_data,
    output aqe_pkg::t_cfg                     o_cfg
);

    logic [aqe_pkg::CPR_W-1:0]  r_cpr_one;
    logic [aqe_pkg::CPR_W-1:0]  r_cpr_two;
    logic [aqe_pkg::AXES_W-1:0] r_axes;
    logic [aqe_pkg::CPR_W-1:0]  cpr_one_clamped;
    logic [aqe_pkg::CPR_W-1:0]  cpr_two_clamped;

    // store register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr_one <= aqe_pkg::CPR_MIN;
            r_cpr_two <= aqe_pkg::CPR_MIN;
            r_axes    <= aqe_pkg::AXES_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                aqe_pkg::REG_CPR_ONE: r_cpr_one <= i_cfg_data;
                aqe_pkg::REG_CPR_TWO: r_cpr_two <= i_cfg_data;
                aqe_pkg::REG_AXES:    r_axes    <= i_cfg_data[aqe_pkg::AXES_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp counts into the supported range
    function automatic logic [aqe_pkg::CPR_W-1:0] clamp_cpr(
        input logic [aqe_pkg::CPR_W-1:0] v
    );
        logic [aqe_pkg::CPR_W-1:0] res;
        res = v;
        if (v < aqe_pkg::CPR_MIN) begin
            res = aqe_pkg::CPR_MIN;
        end else if (v > aqe_pkg::CPR_MAX) begin
            res = aqe_pkg::CPR_MAX;
        end
        return res;
    endfunction

    assign cpr_one_clamped = clamp_cpr(r_cpr_one);
    assign cpr_two_clamped = clamp_cpr(r_cpr_two);

    // x4 period, clear strobes, axis mode (zero acts as one, three as two)
    always_comb begin
        o_cfg.period_one = {cpr_one_clamped, 2'b00};
        o_cfg.period_two = {cpr_two_clamped, 2'b00};
        o_cfg.two_axes   = r_axes[1];
        o_cfg.clr_one    = i_cfg_we && (i_cfg_index == aqe_pkg::REG_CPR_ONE);
        o_cfg.clr_two    = i_cfg_we && (i_cfg_index == aqe_pkg::REG_CPR_TWO);
    end

endmodule

`default_nettype wire

FILE: design/aqe_axis.sv
// ---------------------------------------------------------------------------
// aqe_axis: one emulated encoder axis
// Holds the axis state and works out its next value for an initialize or
// update request: wrap, scale with rounding, modulo add, phase and index.
// ---------------------------------------------------------------------------
`default_nettype none

module aqe_axis (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_apply,
    input  wire logic                       i_init,
    input  wire logic [aqe_pkg::ANGLE_W-1:0] i_angle,
    input  wire logic [aqe_pkg::COUNT_W-1:0] i_period,
    input  wire logic                       i_clr,
    output aqe_pkg::t_axis_st               o_state,
    output aqe_pkg::t_axis_st               o_next
);

    aqe_pkg::t_axis_st r_st;
    aqe_pkg::t_axis_st n_st;

    logic [aqe_pkg::ANGLE_W-1:0] diff;
    logic [aqe_pkg::ANGLE_W-1:0] mag;
    logic                        neg;
    logic [aqe_pkg::ANGLE_W-1:0] mul_a;
    logic [aqe_pkg::PROD_W-1:0]  prod;
    logic [aqe_pkg::PROD_W-1:0]  scaled_full;
    logic [aqe_pkg::COUNT_W-1:0] step;
    logic [aqe_pkg::COUNT_W:0]   sum_up;
    logic [aqe_pkg::COUNT_W:0]   sum_wrap;
    logic [aqe_pkg::COUNT_W-1:0] cnt;
    logic                        moved;
    logic                        pa;
    logic                        pb;

    // wrap the angle change into plus or minus half a turn
    always_comb begin
        diff = i_angle - r_st.last_angle;
        if (diff > aqe_pkg::ANGLE_HALF) begin
            neg = 1'b1;
            mag = aqe_pkg::ANGLE_W'(0) - diff;
        end else if (diff == aqe_pkg::ANGLE_HALF) begin
            neg = !(i_angle > r_st.last_angle);
            mag = diff;
        end else begin
            neg = 1'b0;
            mag = diff;
        end
    end

    // one shared multiplier: start angle on initialize, magnitude on update
    always_comb begin
        mul_a = i_init ? i_angle : mag;
        prod  = aqe_pkg::PROD_W'(mul_a) * aqe_pkg::PROD_W'(i_period);
        // round half away from zero on update only
        scaled_full = i_init ? prod
                             : prod + aqe_pkg::PROD_W'(aqe_pkg::ANGLE_HALF);
        step  = scaled_full[aqe_pkg::PROD_W-1:aqe_pkg::ANGLE_W];
    end

    // add or subtract the step modulo the period
    always_comb begin
        sum_up   = {1'b0, r_st.position} + {1'b0, step};
        sum_wrap = {1'b0, r_st.position} + {1'b0, i_period} - {1'b0, step};
        if (neg) begin
            cnt = (r_st.position >= step) ? (r_st.position - step)
                                          : sum_wrap[aqe_pkg::COUNT_W-1:0];
        end else begin
            cnt = (sum_up >= {1'b0, i_period})
                ? aqe_pkg::COUNT_W'(sum_up - {1'b0, i_period})
                : sum_up[aqe_pkg::COUNT_W-1:0];
        end
        moved = (step != '0);
    end

    // quadrature phases follow count mod 4 only when the count moved
    always_comb begin
        pa = r_st.phase_a;
        pb = r_st.phase_b;
        if (moved) begin
            case (cnt[1:0])
                2'd0:    begin pa = 1'b0; pb = 1'b0; end
                2'd1:    begin pa = 1'b1; pb = 1'b0; end
                2'd2:    begin pa = 1'b1; pb = 1'b1; end
                default: begin pa = 1'b0; pb = 1'b1; end
            endcase
        end
    end

    // next state of the axis
    always_comb begin
        n_st = r_st;
        if (i_clr) begin
            n_st.position = '0;
        end
        if (i_apply) begin
            n_st.last_angle = i_angle;
            if (i_init) begin
                n_st.position   = step;
                n_st.phase_a    = 1'b0;
                n_st.phase_b    = 1'b0;
                n_st.index      = (i_angle == '0);
                n_st.calibrated = 1'b1;
            end else begin
                n_st.position = cnt;
                n_st.phase_a  = pa;
                n_st.phase_b  = pb;
                n_st.index    = (cnt == '0) || (cnt == i_period - aqe_pkg::COUNT_W'(1));
                // zero angle with both channels low snaps to the home count
                if ((i_angle == '0) && !pa && !pb) begin
                    n_st.index    = 1'b1;
                    n_st.position = '0;
                end
            end
        end
    end

    // hold axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_state = r_st;
    assign o_next  = n_st;

endmodule

`default_nettype wire

FILE: design/angle_to_quadrature_emulator.sv
// ---------------------------------------------------------------------------
// angle_to_quadrature_emulator: absolute angle to x4 quadrature emulator
// Turns angle readings for one or two axes into A/B channels, an index
// pulse and position counts, one result per request.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  request  | in        | i_in_valid / o_in_ready | i_in_data  (t_in)
//  result   | out       | o_out_valid/ i_out_ready| o_out_data (t_out)
//  config   | in        | i_cfg_we                | i_cfg_index, i_cfg_data
//
//  An accepted request is held in the input register and is resolved into
//  the axis state and the result register once that register is free; one
//  request per cycle is sustained while the result side does not stall. The
//  single pass through one 16x16 multiply and a modulo add per axis allows
//  that rate.
//  Reset clears all axis state and sets both counts and the axis count to one.
//  A stalled result holds the input register, which then holds the request side.
// ---------------------------------------------------------------------------
`default_nettype none

module angle_to_quadrature_emulator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire aqe_pkg::t_in                  i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output aqe_pkg::t_out                      o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [aqe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [aqe_pkg::CPR_W-1:0]     i_cfg_data
);

    aqe_pkg::t_cfg     cfg;
    aqe_pkg::t_in      r_in;
    logic              r_in_valid;
    aqe_pkg::t_out     r_out;
    aqe_pkg::t_out     n_out;
    logic              r_out_valid;
    aqe_pkg::t_axis_st st_one;
    aqe_pkg::t_axis_st st_two;
    aqe_pkg::t_axis_st nx_one;
    aqe_pkg::t_axis_st nx_two;
    logic              fire;
    logic              is_init;
    logic              reject;
    logic              apply_one;
    logic              apply_two;

    aqe_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // resolve the held request when the result register is free
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // refuse an update until every active axis is calibrated
    always_comb begin
        is_init   = (r_in.kind == aqe_pkg::KIND_INIT);
        reject    = !is_init && (!st_one.calibrated || (cfg.two_axes && !st_two.calibrated));
        apply_one = fire && !reject;
        apply_two = fire && !reject && cfg.two_axes;
    end

    aqe_axis u_axis_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_apply (apply_one),
        .i_init  (is_init),
        .i_angle (r_in.angle_one),
        .i_period(cfg.period_one),
        .i_clr   (cfg.clr_one),
        .o_state (st_one),
        .o_next  (nx_one)
    );

    aqe_axis u_axis_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_apply (apply_two),
        .i_init  (is_init),
        .i_angle (r_in.angle_two),
        .i_period(cfg.period_two),
        .i_clr   (cfg.clr_two),
        .o_state (st_two),
        .o_next  (nx_two)
    );

    // build the result from the state after the request
    always_comb begin
        n_out.chan_a_one  = nx_one.phase_a;
        n_out.chan_b_one  = nx_one.phase_b;
        n_out.chan_a_two  = cfg.two_axes && nx_two.phase_a;
        n_out.chan_b_two  = cfg.two_axes && nx_two.phase_b;
        n_out.index_pulse = nx_one.index || (cfg.two_axes && nx_two.index);
        n_out.count_one   = nx_one.position;
        n_out.count_two   = nx_two.position;
        n_out.rejected    = reject;
    end

    // input register: take a request whenever it is free or draining
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // result register: load on resolve, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: design/aqe_checker.sv
// ---------------------------------------------------------------------------
// aqe_checker: port-level checks for the quadrature emulator
// Watches the request, result and reset behaviour seen at the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module aqe_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_in_ready,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire aqe_pkg::t_out o_out_data
);

    // a stalled result holds its value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // reset leaves no result pending
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // the request side only stalls behind a stalled result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("request stalled without a stalled result");

    // counts stay within the largest period
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.count_one < aqe_pkg::COUNT_W'(4 * aqe_pkg::MAX_COUNTS))
                     && (o_out_data.count_two < aqe_pkg::COUNT_W'(4 * aqe_pkg::MAX_COUNTS)))
        else $error("count out of range");

endmodule

bind angle_to_quadrature_emulator aqe_checker u_aqe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

FILE: tb/angle_to_quadrature_emulator_tb.sv
// ---------------------------------------------------------------------------
// angle_to_quadrature_emulator_tb: self-checking bench for the x4 emulator
// Drives initialize and update requests through the valid/ready request
// channel, predicts the channel, index, count and rejected fields of every
// result from a behavioural copy of the axis state, and compares each result
// in order. Covers rejection before calibration, half-turn ties, the forced
// zero at angle zero, clamped register values, one and two axes, random
// angle walks, long result stalls and a sender pause.
// ---------------------------------------------------------------------------
`default_nettype none

module angle_to_quadrature_emulator_tb;

    localparam int HOLD_CYCLES = 300;
    localparam int RUN_LIMIT   = 10_000_000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    aqe_pkg::t_in                  i_in_data;
    logic                          o_out_valid;
    logic                          i_out_ready;
    aqe_pkg::t_out                 o_out_data;
    logic                          i_cfg_we;
    logic [aqe_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [aqe_pkg::CPR_W-1:0]     i_cfg_data;

    // behavioural copy of the axis state and registers
    logic [aqe_pkg::ANGLE_W-1:0] ax_last [2];
    logic [aqe_pkg::COUNT_W-1:0] ax_pos  [2];
    logic                        ax_a    [2];
    logic                        ax_b    [2];
    logic                        ax_idx  [2];
    logic                        ax_cal  [2];
    logic [aqe_pkg::CPR_W-1:0]   cpr_reg [2];
    logic [aqe_pkg::AXES_W-1:0]  axes_reg;

    aqe_pkg::t_out               expected_q [$];
    logic [aqe_pkg::ANGLE_W-1:0] sent_angle [2];
    int                          fail_count;
    int                          holds_wanted;
    int                          holds_served;
    bit                          no_gaps;

    angle_to_quadrature_emulator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("FAIL");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------
    function automatic longint unsigned axis_period(int ax);
        longint unsigned c;
        c = 64'(cpr_reg[ax]);
        if (c < 1) c = 1;
        if (c > aqe_pkg::MAX_COUNTS) c = aqe_pkg::MAX_COUNTS;
        return 4 * c;
    endfunction

    function automatic void init_axis(int ax, logic [aqe_pkg::ANGLE_W-1:0] ang);
        longint unsigned p;
        p = axis_period(ax);
        ax_last[ax] = ang;
        ax_pos[ax]  = aqe_pkg::COUNT_W'(((64'(ang) * p) >> aqe_pkg::ANGLE_W) % p);
        ax_a[ax]    = 1'b0;
        ax_b[ax]    = 1'b0;
        ax_idx[ax]  = (ang == '0);
        ax_cal[ax]  = 1'b1;
    endfunction

    function automatic void step_axis(int ax, logic [aqe_pkg::ANGLE_W-1:0] cur);
        longint unsigned             p, mag, raw, step, cnt;
        logic [aqe_pkg::ANGLE_W-1:0] d;
        logic                        neg;
        p = axis_period(ax);
        d = cur - ax_last[ax];
        // wrap into plus or minus half a turn; a tie keeps the plain sign
        if (d > aqe_pkg::ANGLE_HALF) begin
            neg = 1'b1;
            mag = (64'(1) << aqe_pkg::ANGLE_W) - 64'(d);
        end else if (d == aqe_pkg::ANGLE_HALF) begin
            neg = !(cur > ax_last[ax]);
            mag = 64'(d);
        end else begin
            neg = 1'b0;
            mag = 64'(d);
        end
        raw  = (mag * p + 64'(aqe_pkg::ANGLE_HALF)) >> aqe_pkg::ANGLE_W;
        step = raw % p;
        cnt  = 64'(ax_pos[ax]) % p;
        cnt  = neg ? (cnt + p - step) % p : (cnt + step) % p;
        ax_pos[ax] = aqe_pkg::COUNT_W'(cnt);
        // Gray sequence 00, 10, 11, 01 only when the rounded change is nonzero
        if (raw != 0) begin
            ax_a[ax] = cnt[0] ^ cnt[1];
            ax_b[ax] = cnt[1];
        end
        ax_idx[ax] = (cnt == 0) || (cnt == p - 1);
        if (cur == '0 && !ax_a[ax] && !ax_b[ax]) begin
            ax_idx[ax] = 1'b1;
            ax_pos[ax] = '0;
        end
        ax_last[ax] = cur;
    endfunction

    function automatic aqe_pkg::t_out advance_emulator(aqe_pkg::t_in req);
        aqe_pkg::t_out res;
        logic          two;
        two = (axes_reg >= 2'd2);
        res = '0;
        if (req.kind == aqe_pkg::KIND_INIT) begin
            init_axis(0, req.angle_one);
            if (two) init_axis(1, req.angle_two);
        end else if (!ax_cal[0] || (two && !ax_cal[1])) begin
            res.rejected = 1'b1;
        end else begin
            step_axis(0, req.angle_one);
            if (two) step_axis(1, req.angle_two);
        end
        res.chan_a_one  = ax_a[0];
        res.chan_b_one  = ax_b[0];
        res.chan_a_two  = two & ax_a[1];
        res.chan_b_two  = two & ax_b[1];
        res.index_pulse = ax_idx[0] | (two & ax_idx[1]);
        res.count_one   = ax_pos[0];
        res.count_two   = ax_pos[1];
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Result checking
    // -----------------------------------------------------------------------
    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        aqe_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("chan_a_one",  16'(want.chan_a_one),  16'(o_out_data.chan_a_one));
                check_field("chan_b_one",  16'(want.chan_b_one),  16'(o_out_data.chan_b_one));
                check_field("chan_a_two",  16'(want.chan_a_two),  16'(o_out_data.chan_a_two));
                check_field("chan_b_two",  16'(want.chan_b_two),  16'(o_out_data.chan_b_two));
                check_field("index_pulse", 16'(want.index_pulse),
                            16'(o_out_data.index_pulse));
                check_field("count_one",   want.count_one,   o_out_data.count_one);
                check_field("count_two",   want.count_two,   o_out_data.count_two);
                check_field("rejected",    16'(want.rejected),    16'(o_out_data.rejected));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then long
    // -----------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    // Result side: random stalls, plus long hold-offs on request
    initial begin
        int run;
        int gap;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (holds_served < holds_wanted) begin
                holds_served++;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (no_gaps) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                run = $urandom_range(1, 12);
                gap = pick_gap();
                i_out_ready <= 1'b1;
                repeat (run) @(posedge i_clk);
                if (gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Request side
    // -----------------------------------------------------------------------
    task automatic send_request(input aqe_pkg::t_in req);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_q.push_back(advance_emulator(req));
        sent_angle[0] = req.angle_one;
        sent_angle[1] = req.angle_two;
    endtask

    function automatic aqe_pkg::t_in make_req(logic kind, logic [15:0] a1, logic [15:0] a2);
        aqe_pkg::t_in req;
        req.kind      = kind;
        req.angle_one = a1;
        req.angle_two = a2;
        return req;
    endfunction

    function automatic logic [aqe_pkg::ANGLE_W-1:0] rand_angle();
        return aqe_pkg::ANGLE_W'($urandom());
    endfunction

    // drop valid and hold until every outstanding result has been taken
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [aqe_pkg::CFG_IDX_W-1:0] idx,
                             logic [aqe_pkg::CPR_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            aqe_pkg::REG_CPR_ONE: begin
                cpr_reg[0] = val;
                ax_pos[0]  = '0;
            end
            aqe_pkg::REG_CPR_TWO: begin
                cpr_reg[1] = val;
                ax_pos[1]  = '0;
            end
            aqe_pkg::REG_AXES: begin
                axes_reg = val[aqe_pkg::AXES_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic set_config(int c1, int c2, int axes);
        wait_drained();
        write_reg(aqe_pkg::REG_CPR_ONE, aqe_pkg::CPR_W'(c1));
        write_reg(aqe_pkg::REG_CPR_TWO, aqe_pkg::CPR_W'(c2));
        write_reg(aqe_pkg::REG_AXES, aqe_pkg::CPR_W'(axes));
    endtask

    // next angle of a walk: mostly small and medium steps, some ties and zeros
    function automatic logic [15:0] next_angle(logic [15:0] prev);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 30)      v = int'(prev) + $urandom_range(0, 80) - 40;
        else if (r < 55) v = int'(prev) + $urandom_range(0, 4000) - 2000;
        else if (r < 63) v = int'(prev) + int'(aqe_pkg::ANGLE_HALF);
        else if (r < 68) v = int'(prev);
        else if (r < 76) v = 0;
        else if (r < 84) v = int'(prev) + ($urandom_range(0, 1) ? 1 : -1)
                             * (int'(aqe_pkg::ANGLE_HALF) - $urandom_range(1, 8));
        else             v = $urandom();
        return v[15:0];
    endfunction

    task automatic send_random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 7)
            send_request(make_req(aqe_pkg::KIND_INIT, rand_angle(), rand_angle()));
        else if (r < 10)
            send_request(make_req(aqe_pkg::KIND_INIT, next_angle(sent_angle[0]),
                                  next_angle(sent_angle[1])));
        else
            send_request(make_req(aqe_pkg::KIND_UPDATE, next_angle(sent_angle[0]),
                                  next_angle(sent_angle[1])));
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    task automatic test_reject_before_init();
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'h0000, 16'h0000));
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'hFFFF, 16'hFFFF));
        // one axis: only axis one is calibrated
        send_request(make_req(aqe_pkg::KIND_INIT, 16'h0000, 16'hFFFF));
        wait_drained();
        write_reg(aqe_pkg::REG_AXES, aqe_pkg::CPR_W'(2));
        // axis two still uncalibrated
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'h4000, 16'h4000));
        send_request(make_req(aqe_pkg::KIND_INIT, 16'hFFFF, 16'h8000));
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'h3FFF, 16'hC000));
    endtask

    task automatic test_directed_cases();
        // clamped registers, and an index that maps to no register
        set_config(0, 16383, 2);
        write_reg(2'd3, 14'h3FFF);
        send_request(make_req(aqe_pkg::KIND_INIT,   16'h0000, 16'h0000));
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'h4000, 16'h0001));
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'h8000, 16'h8001));
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'hC000, 16'h0001));
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'h0000, 16'h0001));
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'h2000, 16'h0001));
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'h0000, 16'h0000));
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'hFFFF, 16'hFFFF));
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'h8000, 16'h7FFF));
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'h0000, 16'h0000));
        // largest period, axis count of three acts as two
        set_config(9000, 1, 3);
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'h1234, 16'h4321));
        send_request(make_req(aqe_pkg::KIND_INIT,   16'hFFFF, 16'hFFFF));
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'h0000, 16'h0000));
        send_request(make_req(aqe_pkg::KIND_UPDATE, 16'hFFFF, 16'hFFFF));
    endtask

    task automatic run_random_setting(int c1, int c2, int axes, int n);
        set_config(c1, c2, axes);
        if ($urandom_range(0, 1))
            send_request(make_req(aqe_pkg::KIND_INIT, rand_angle(), rand_angle()));
        repeat (n) send_random_request();
    endtask

    task automatic test_random_walks();
        run_random_setting(1, 1, 1, 80);
        run_random_setting(9000, 9000, 2, 100);
        run_random_setting(16383, 0, 3, 80);
        run_random_setting(0, 9000, 0, 60);
        repeat (4) begin
            run_random_setting($urandom_range(1, 9000), $urandom_range(1, 64),
                               $urandom_range(0, 3), 100);
        end
    endtask

    task automatic test_result_holdoff();
        set_config($urandom_range(1, 9000), $urandom_range(1, 9000), 2);
        send_request(make_req(aqe_pkg::KIND_INIT, rand_angle(), rand_angle()));
        // back to back on both sides, then stall the result side
        no_gaps = 1'b1;
        repeat (30) send_random_request();
        holds_wanted++;
        repeat (40) send_random_request();
        no_gaps = 1'b0;
    endtask

    task automatic test_sender_pause();
        repeat (20) send_random_request();
        wait_drained();
        repeat (20) send_random_request();
    endtask

    // -----------------------------------------------------------------------
    // Sequence
    // -----------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        fail_count   = 0;
        holds_wanted = 0;
        holds_served = 0;
        no_gaps      = 1'b0;
        for (int i = 0; i < 2; i++) begin
            ax_last[i]    = '0;
            ax_pos[i]     = '0;
            ax_a[i]       = 1'b0;
            ax_b[i]       = 1'b0;
            ax_idx[i]     = 1'b0;
            ax_cal[i]     = 1'b0;
            cpr_reg[i]    = aqe_pkg::CPR_W'(1);
            sent_angle[i] = '0;
        end
        axes_reg = aqe_pkg::AXES_W'(1);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reject_before_init();
        test_directed_cases();
        test_random_walks();
        test_result_holdoff();
        test_sender_pause();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: angle_to_quadrature_emulator.f
design/aqe_pkg.sv
design/aqe_cfg.sv
design/aqe_axis.sv
design/angle_to_quadrature_emulator.sv
design/aqe_checker.sv
tb/angle_to_quadrature_emulator_tb.sv
